[hw/rtl/sac_pkg.sv]
// Shared types, constants and helper functions for the slab allocator.
package sac_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int LINK_W      = SLOT_W + 1;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int SUM_W       = CNT_W + 1;
    localparam int CLASS_DEPTH = 512;
    localparam int THROTTLE_SECS = 5;

    localparam logic [LINK_W-1:0] NIL_LINK = '1;
    localparam logic [15:0]       REF_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_ALLOC    = 3'd1,
        MODE_ACQUIRE  = 3'd2,
        MODE_RELEASE  = 3'd3,
        MODE_INVAL    = 3'd4,
        MODE_GC       = 3'd5,
        MODE_GC_FORCE = 3'd6,
        MODE_GC_AUTO  = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NO_FREE   = 3'd1,
        STS_REF_OVF   = 3'd2,
        STS_THROTTLED = 3'd3,
        STS_COUNTS    = 3'd4
    } status_t;

    localparam logic [2:0] CFG_SMALL_LOG2  = 3'd0;
    localparam logic [2:0] CFG_MEDIUM_LOG2 = 3'd1;
    localparam logic [2:0] CFG_LARGE_LOG2  = 3'd2;
    localparam logic [2:0] CFG_SMALL_CNT   = 3'd3;
    localparam logic [2:0] CFG_MEDIUM_CNT  = 3'd4;
    localparam logic [2:0] CFG_LARGE_CNT   = 3'd5;

    typedef struct packed {
        logic       busy;
        logic [1:0] cls;
    } meta_t;

    // Chunk bytes of a class; log2 values above 16 saturate.
    function automatic logic [16:0] chunk_bytes(input logic [4:0] lg);
        logic [4:0] l;
        l = (lg > 5'd16) ? 5'd16 : lg;
        return 17'd1 << l;
    endfunction

    function automatic logic [9:0] clamp_count(input logic [9:0] n);
        return (n > 10'(CLASS_DEPTH)) ? 10'(CLASS_DEPTH) : n;
    endfunction

endpackage

[hw/rtl/slab_allocator_with_refcount_gc.sv]
// Top level: three-class slab allocator with reference counts and throttled gc sweep.
// Throughput: one item at a time; in_ready returns as the result loads, and a finished
// result that finds the output register full holds in_ready low until out_ready.
// Reset clears the busy flags one slot a cycle, with in_ready held low.
module slab_allocator_with_refcount_gc
    import sac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [9:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [23:0] alloc_size,
    input  logic [31:0] timeout_secs,
    input  logic [9:0]  slot_handle,
    input  logic [31:0] now_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [9:0]  handle_out,
    output logic [1:0]  size_class,
    output logic [16:0] capacity,
    output logic [15:0] ref_out,
    output logic [10:0] reclaimed
);

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b000_0000_0001,
        ST_IDLE     = 11'b000_0000_0010,
        ST_ALLOC_WR = 11'b000_0000_0100,
        ST_REF_WR   = 11'b000_0000_1000,
        ST_INV_WR   = 11'b000_0001_0000,
        ST_INIT     = 11'b000_0010_0000,
        ST_SWEEP    = 11'b000_0100_0000,
        ST_EMIT     = 11'b000_1000_0000,
        ST_SPARE0   = 11'b001_0000_0000,
        ST_SPARE1   = 11'b010_0000_0000,
        ST_SPARE2   = 11'b100_0000_0000
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               eval_vld_reg, eval_vld_next;
    logic [4:0]         lg_reg [3];
    logic [4:0]         lg_next [3];
    logic [9:0]         ccnt_reg [3];
    logic [9:0]         ccnt_next [3];
    logic [LINK_W-1:0]  head_reg [3];
    logic [LINK_W-1:0]  head_next [3];
    logic [31:0]        last_sweep_reg, last_sweep_next;
    logic [CNT_W-1:0]   busy_total_reg, busy_total_next;
    logic [CNT_W-1:0]   pool_total_reg, pool_total_next;
    logic               out_valid_reg, out_valid_next;

    // Item and result payload
    mode_t              mode_reg, mode_next;
    logic [31:0]        tmo_reg, tmo_next;
    logic [31:0]        now_reg, now_next;
    logic [1:0]         cls_reg, cls_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0]  eval_idx_reg, eval_idx_next;
    logic [CNT_W-1:0]   end0_reg, end0_next;
    logic [CNT_W-1:0]   end1_reg, end1_next;
    logic [CNT_W-1:0]   end2_reg, end2_next;
    logic [CNT_W-1:0]   freed_reg, freed_next;
    status_t            res_status_reg, res_status_next;
    logic [9:0]         res_handle_reg, res_handle_next;
    logic [1:0]         res_class_reg, res_class_next;
    logic [16:0]        res_cap_reg, res_cap_next;
    logic [15:0]        res_ref_reg, res_ref_next;
    logic [10:0]        res_recl_reg, res_recl_next;
    status_t            status_reg, status_next;
    logic [9:0]         handle_reg, handle_next;
    logic [1:0]         class_reg, class_next;
    logic [16:0]        cap_reg, cap_next;
    logic [15:0]        ref_reg, ref_next;
    logic [10:0]        recl_reg, recl_next;

    // Slot RAM ports
    logic [SLOT_W-1:0]  waddr, raddr;
    logic               we_link, we_meta, we_ref, we_birth, we_life;
    logic [LINK_W-1:0]  wd_link, rd_link;
    meta_t              wd_meta, rd_meta;
    logic [15:0]        wd_ref, rd_ref;
    logic [31:0]        wd_birth, rd_birth, wd_life, rd_life;

    // Decode helpers
    logic [9:0]         n0, n1, n2;
    logic [SUM_W-1:0]   n_sum;
    logic [2:0]         fit;
    logic [CNT_W+2:0]   busy5, pool4;
    logic               force_gc, throttled, h_ok, expired;
    logic [31:0]        eff_last;
    logic [CNT_W-1:0]   cnt_inc;
    logic [1:0]         free_cls;

    sac_ram #(.WIDTH(LINK_W), .DEPTH(MAX_SLOTS)) u_link (
        .clk(clk), .we(we_link), .waddr(waddr), .wdata(wd_link),
        .raddr(raddr), .rdata(rd_link)
    );

    sac_ram #(.WIDTH($bits(meta_t)), .DEPTH(MAX_SLOTS)) u_meta (
        .clk(clk), .we(we_meta), .waddr(waddr), .wdata(wd_meta),
        .raddr(raddr), .rdata(rd_meta)
    );

    sac_ram #(.WIDTH(16), .DEPTH(MAX_SLOTS)) u_ref (
        .clk(clk), .we(we_ref), .waddr(waddr), .wdata(wd_ref),
        .raddr(raddr), .rdata(rd_ref)
    );

    sac_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_birth (
        .clk(clk), .we(we_birth), .waddr(waddr), .wdata(wd_birth),
        .raddr(raddr), .rdata(rd_birth)
    );

    sac_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_life (
        .clk(clk), .we(we_life), .waddr(waddr), .wdata(wd_life),
        .raddr(raddr), .rdata(rd_life)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign handle_out = handle_reg;
    assign size_class = class_reg;
    assign capacity   = cap_reg;
    assign ref_out    = ref_reg;
    assign reclaimed  = recl_reg;

    // Class sizing and fit checks against the live configuration
    assign n0    = clamp_count(ccnt_reg[0]);
    assign n1    = clamp_count(ccnt_reg[1]);
    assign n2    = clamp_count(ccnt_reg[2]);
    assign n_sum = SUM_W'(n0) + SUM_W'(n1) + SUM_W'(n2);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            fit[c] = ({7'd0, chunk_bytes(lg_reg[c])} >= alloc_size) &&
                     (head_reg[c] < LINK_W'(MAX_SLOTS));
        end
    end

    // Auto gc forces a sweep above 80% occupancy: busy*5 > pool*4
    assign busy5     = (CNT_W+3)'({busy_total_reg, 2'b00}) + (CNT_W+3)'(busy_total_reg);
    assign pool4     = (CNT_W+3)'({pool_total_reg, 2'b00});
    assign force_gc  = (mode == MODE_GC_FORCE) || ((mode == MODE_GC_AUTO) && (busy5 > pool4));
    assign eff_last  = force_gc ? 32'd0 : last_sweep_reg;
    assign throttled = ((now_time - eff_last) < 32'(THROTTLE_SECS));
    assign h_ok      = (32'(slot_handle) < 32'(MAX_SLOTS));
    assign expired   = (rd_life != 32'd0) && ((now_reg - rd_birth) >= rd_life);
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign free_cls  = (rd_meta.cls == 2'd3) ? 2'd2 : rd_meta.cls;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        eval_vld_next   = eval_vld_reg;
        lg_next         = lg_reg;
        ccnt_next       = ccnt_reg;
        head_next       = head_reg;
        last_sweep_next = last_sweep_reg;
        busy_total_next = busy_total_reg;
        pool_total_next = pool_total_reg;
        out_valid_next  = out_valid_reg;
        mode_next       = mode_reg;
        tmo_next        = tmo_reg;
        now_next        = now_reg;
        cls_next        = cls_reg;
        idx_next        = idx_reg;
        eval_idx_next   = eval_idx_reg;
        end0_next       = end0_reg;
        end1_next       = end1_reg;
        end2_next       = end2_reg;
        freed_next      = freed_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_class_next  = res_class_reg;
        res_cap_next    = res_cap_reg;
        res_ref_next    = res_ref_reg;
        res_recl_next   = res_recl_reg;
        status_next     = status_reg;
        handle_next     = handle_reg;
        class_next      = class_reg;
        cap_next        = cap_reg;
        ref_next        = ref_reg;
        recl_next       = recl_reg;

        waddr    = idx_reg;
        raddr    = idx_reg;
        we_link  = 1'b0;
        we_meta  = 1'b0;
        we_ref   = 1'b0;
        we_birth = 1'b0;
        we_life  = 1'b0;
        wd_link  = NIL_LINK;
        wd_meta  = '0;
        wd_ref   = 16'd0;
        wd_birth = 32'd0;
        wd_life  = 32'd0;

        // Configuration writes land whenever the enable is high
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SMALL_LOG2:  lg_next[0]   = cfg_wdata[4:0];
                CFG_MEDIUM_LOG2: lg_next[1]   = cfg_wdata[4:0];
                CFG_LARGE_LOG2:  lg_next[2]   = cfg_wdata[4:0];
                CFG_SMALL_CNT:   ccnt_next[0] = cfg_wdata;
                CFG_MEDIUM_CNT:  ccnt_next[1] = cfg_wdata;
                CFG_LARGE_CNT:   ccnt_next[2] = cfg_wdata;
                default:         ;
            endcase
        end

        // Drop the output once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Post-reset pass: mark every slot idle
                waddr    = cnt_reg[SLOT_W-1:0];
                we_meta  = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_reg == CNT_W'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode_t'(mode);
                    tmo_next        = timeout_secs;
                    now_next        = now_time;
                    idx_next        = SLOT_W'(slot_handle);
                    raddr           = SLOT_W'(slot_handle);
                    res_status_next = STS_OK;
                    res_handle_next = 10'd0;
                    res_class_next  = 2'd0;
                    res_cap_next    = 17'd0;
                    res_ref_next    = 16'd0;
                    res_recl_next   = 11'd0;
                    state_next      = ST_EMIT;
                    unique case (mode_t'(mode))
                        MODE_INIT:
                        begin
                            if (n_sum > SUM_W'(MAX_SLOTS))
                            begin
                                res_status_next = STS_COUNTS;
                            end
                            else
                            begin
                                end0_next = CNT_W'(n0);
                                end1_next = CNT_W'(n0) + CNT_W'(n1);
                                end2_next = CNT_W'(n_sum);
                                head_next[0] = (n0 != 10'd0) ? LINK_W'(0) : NIL_LINK;
                                head_next[1] = (n1 != 10'd0) ? LINK_W'(n0) : NIL_LINK;
                                head_next[2] = (n2 != 10'd0) ?
                                               (LINK_W'(n0) + LINK_W'(n1)) : NIL_LINK;
                                pool_total_next = CNT_W'(n_sum);
                                busy_total_next = '0;
                                last_sweep_next = 32'd0;
                                cnt_next        = '0;
                                state_next      = ST_INIT;
                            end
                        end
                        MODE_ALLOC:
                        begin
                            // First fitting class with a free chunk wins: small, then medium, then large
                            priority if (fit[0])
                            begin
                                cls_next = 2'd0;
                            end
                            else if (fit[1])
                            begin
                                cls_next = 2'd1;
                            end
                            else
                            begin
                                cls_next = 2'd2;
                            end
                            if (fit != 3'b000)
                            begin
                                idx_next   = head_reg[cls_next][SLOT_W-1:0];
                                raddr      = head_reg[cls_next][SLOT_W-1:0];
                                state_next = ST_ALLOC_WR;
                            end
                            else
                            begin
                                res_status_next = STS_NO_FREE;
                            end
                        end
                        MODE_ACQUIRE, MODE_RELEASE:
                        begin
                            if (h_ok)
                            begin
                                state_next = ST_REF_WR;
                            end
                        end
                        MODE_INVAL:
                        begin
                            if (h_ok)
                            begin
                                state_next = ST_INV_WR;
                            end
                        end
                        MODE_GC, MODE_GC_FORCE, MODE_GC_AUTO:
                        begin
                            if (force_gc)
                            begin
                                last_sweep_next = 32'd0;
                            end
                            if (throttled)
                            begin
                                res_status_next = STS_THROTTLED;
                            end
                            else
                            begin
                                last_sweep_next = now_time;
                                cnt_next        = '0;
                                eval_vld_next   = 1'b0;
                                freed_next      = '0;
                                state_next      = ST_SWEEP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_ALLOC_WR:
            begin
                // Pop the head chunk and stamp the slot
                head_next[cls_reg] = rd_link;
                we_meta         = 1'b1;
                wd_meta.busy    = 1'b1;
                wd_meta.cls     = cls_reg;
                we_ref          = 1'b1;
                we_birth        = 1'b1;
                wd_birth        = now_reg;
                we_life         = 1'b1;
                wd_life         = tmo_reg;
                busy_total_next = busy_total_reg + CNT_W'(1);
                res_handle_next = 10'(idx_reg);
                res_class_next  = cls_reg;
                res_cap_next    = chunk_bytes(lg_reg[cls_reg]);
                state_next      = ST_EMIT;
            end

            ST_REF_WR:
            begin
                res_ref_next = rd_ref;
                if (mode_reg == MODE_ACQUIRE)
                begin
                    if (rd_ref == REF_MAX)
                    begin
                        res_status_next = STS_REF_OVF;
                    end
                    else
                    begin
                        we_ref       = 1'b1;
                        wd_ref       = rd_ref + 16'd1;
                        res_ref_next = rd_ref + 16'd1;
                    end
                end
                else if (rd_ref != 16'd0)
                begin
                    we_ref       = 1'b1;
                    wd_ref       = rd_ref - 16'd1;
                    res_ref_next = rd_ref - 16'd1;
                end
                state_next = ST_EMIT;
            end

            ST_INV_WR:
            begin
                if (rd_meta.busy)
                begin
                    we_ref  = 1'b1;
                    we_life = 1'b1;
                end
                state_next = ST_EMIT;
            end

            ST_INIT:
            begin
                // Link each class in ascending order; slots past the pool stay unlinked
                waddr    = cnt_reg[SLOT_W-1:0];
                we_link  = 1'b1;
                we_meta  = 1'b1;
                we_ref   = 1'b1;
                we_birth = 1'b1;
                we_life  = 1'b1;
                priority if (cnt_reg < end0_reg)
                begin
                    wd_meta.cls = 2'd0;
                    wd_link     = (cnt_inc == end0_reg) ? NIL_LINK : LINK_W'(cnt_inc);
                end
                else if (cnt_reg < end1_reg)
                begin
                    wd_meta.cls = 2'd1;
                    wd_link     = (cnt_inc == end1_reg) ? NIL_LINK : LINK_W'(cnt_inc);
                end
                else if (cnt_reg < end2_reg)
                begin
                    wd_meta.cls = 2'd2;
                    wd_link     = (cnt_inc == end2_reg) ? NIL_LINK : LINK_W'(cnt_inc);
                end
                else
                begin
                    wd_meta.cls = 2'd0;
                    wd_link     = NIL_LINK;
                end
                cnt_next = cnt_inc;
                if (cnt_reg == CNT_W'(MAX_SLOTS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_SWEEP:
            begin
                // Issue slot reads one a cycle; judge each slot the cycle after
                if (cnt_reg < CNT_W'(MAX_SLOTS))
                begin
                    raddr         = cnt_reg[SLOT_W-1:0];
                    cnt_next      = cnt_inc;
                    eval_vld_next = 1'b1;
                    eval_idx_next = cnt_reg[SLOT_W-1:0];
                end
                else
                begin
                    eval_vld_next = 1'b0;
                end
                if (eval_vld_reg && rd_meta.busy && ((rd_ref == 16'd0) || expired))
                begin
                    waddr               = eval_idx_reg;
                    we_meta             = 1'b1;
                    wd_meta.busy        = 1'b0;
                    wd_meta.cls         = rd_meta.cls;
                    we_ref              = 1'b1;
                    we_birth            = 1'b1;
                    we_life             = 1'b1;
                    we_link             = 1'b1;
                    wd_link             = head_reg[free_cls];
                    head_next[free_cls] = LINK_W'(eval_idx_reg);
                    if (busy_total_reg != '0)
                    begin
                        busy_total_next = busy_total_reg - CNT_W'(1);
                    end
                    freed_next = freed_reg + CNT_W'(1);
                end
                if ((cnt_reg == CNT_W'(MAX_SLOTS)) && !eval_vld_reg)
                begin
                    res_recl_next = 11'(freed_reg);
                    state_next    = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    handle_next    = res_handle_reg;
                    class_next     = res_class_reg;
                    cap_next       = res_cap_reg;
                    ref_next       = res_ref_reg;
                    recl_next      = res_recl_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            eval_vld_reg   <= 1'b0;
            lg_reg[0]      <= 5'd6;
            lg_reg[1]      <= 5'd8;
            lg_reg[2]      <= 5'd10;
            ccnt_reg[0]    <= 10'd64;
            ccnt_reg[1]    <= 10'd64;
            ccnt_reg[2]    <= 10'd12;
            head_reg[0]    <= NIL_LINK;
            head_reg[1]    <= NIL_LINK;
            head_reg[2]    <= NIL_LINK;
            last_sweep_reg <= 32'd0;
            busy_total_reg <= '0;
            pool_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            eval_vld_reg   <= eval_vld_next;
            lg_reg         <= lg_next;
            ccnt_reg       <= ccnt_next;
            head_reg       <= head_next;
            last_sweep_reg <= last_sweep_next;
            busy_total_reg <= busy_total_next;
            pool_total_reg <= pool_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        tmo_reg        <= tmo_next;
        now_reg        <= now_next;
        cls_reg        <= cls_next;
        idx_reg        <= idx_next;
        eval_idx_reg   <= eval_idx_next;
        end0_reg       <= end0_next;
        end1_reg       <= end1_next;
        end2_reg       <= end2_next;
        freed_reg      <= freed_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_class_reg  <= res_class_next;
        res_cap_reg    <= res_cap_next;
        res_ref_reg    <= res_ref_next;
        res_recl_reg   <= res_recl_next;
        status_reg     <= status_next;
        handle_reg     <= handle_next;
        class_reg      <= class_next;
        cap_reg        <= cap_next;
        ref_reg        <= ref_next;
        recl_reg       <= recl_next;
    end

endmodule

[hw/rtl/sac_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sim/tb.sv]
// Self-checking testbench for the three-class slab allocator.
`timescale 1ns / 1ps

module tb;
    import sac_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 1100;   // covers a full sweep or init pass

    // One result of the allocator as seen on its output port.
    typedef struct {
        status_t     st;
        logic [9:0]  hnd;
        logic [1:0]  cls;
        logic [16:0] cap;
        logic [15:0] refs;
        logic [10:0] freed;
    } slab_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [9:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  mode;
    logic [23:0] alloc_size;
    logic [31:0] timeout_secs;
    logic [9:0]  slot_handle;
    logic [31:0] now_time;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [9:0]  handle_out;
    logic [1:0]  size_class;
    logic [16:0] capacity;
    logic [15:0] ref_out;
    logic [10:0] reclaimed;

    slab_allocator_with_refcount_gc DUT (.*);

    // Shadow copy of the allocator state, kept in step with accepted transfers.
    logic [4:0]  sh_log2 [3];
    logic [9:0]  sh_count [3];
    logic [10:0] sh_link [MAX_SLOTS];
    logic [10:0] sh_head [3];
    bit          sh_busy [MAX_SLOTS];
    logic [1:0]  sh_cls [MAX_SLOTS];
    logic [15:0] sh_refs [MAX_SLOTS];
    logic [31:0] sh_born [MAX_SLOTS];
    logic [31:0] sh_life [MAX_SLOTS];
    logic [31:0] sh_last_sweep;
    int unsigned sh_busy_n;
    int unsigned sh_pool_n;
    bit          pool_ready;      // a successful init has been seen

    slab_result_t pending_q[$];
    logic [9:0]   live_handles[$];
    logic [31:0]  clock_secs;

    int  cycles;
    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    int  hold_cycles;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_q.size());
            $display("tb failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when hold_cycles is loaded.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        slab_result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d handle %0d", status,
                             handle_out);
            end
            else
            begin
                w = pending_q.pop_front();
                if (status !== w.st || handle_out !== w.hnd || size_class !== w.cls ||
                    capacity !== w.cap || ref_out !== w.refs || reclaimed !== w.freed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch #%0d: exp st=%0d h=%0d c=%0d cap=%0d ref=%0d ",
                                  "rec=%0d / got st=%0d h=%0d c=%0d cap=%0d ref=%0d rec=%0d"},
                                 results_seen, w.st, w.hnd, w.cls, w.cap, w.refs, w.freed,
                                 status, handle_out, size_class, capacity, ref_out,
                                 reclaimed);
                end
            end
        end
    end

    function automatic logic [16:0] class_bytes(input int c);
        return 17'd1 << ((sh_log2[c] > 5'd16) ? 5'd16 : sh_log2[c]);
    endfunction

    // Return a slot to the head of its class list.
    function automatic void reclaim_slot(input int i);
        sh_busy[i] = 0;
        sh_refs[i] = '0;
        sh_born[i] = '0;
        sh_life[i] = '0;
        sh_link[i] = sh_head[sh_cls[i]];
        sh_head[sh_cls[i]] = 11'(i);
        if (sh_busy_n > 0)
            sh_busy_n--;
    endfunction

    function automatic void run_sweep(input logic [31:0] now, inout slab_result_t r);
        int n;
        n = 0;
        if (now - sh_last_sweep < 32'(THROTTLE_SECS))
        begin
            r.st = STS_THROTTLED;
            return;
        end
        sh_last_sweep = now;
        for (int i = 0; i < MAX_SLOTS; i++)
            if (sh_busy[i] && (sh_refs[i] == 0 ||
                (sh_life[i] != 0 && (now - sh_born[i]) >= sh_life[i])))
            begin
                reclaim_slot(i);
                n++;
            end
        r.freed = 11'(n);
    endfunction

    function automatic void build_pool(inout slab_result_t r);
        int n [3];
        int base;
        for (int c = 0; c < 3; c++)
            n[c] = (sh_count[c] > 10'(CLASS_DEPTH)) ? CLASS_DEPTH : int'(sh_count[c]);
        if (n[0] + n[1] + n[2] > MAX_SLOTS)
        begin
            r.st = STS_COUNTS;
            return;
        end
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            sh_busy[i] = 0;
            sh_cls[i] = '0;
            sh_refs[i] = '0;
            sh_born[i] = '0;
            sh_life[i] = '0;
            sh_link[i] = NIL_LINK;
        end
        base = 0;
        for (int c = 0; c < 3; c++)
        begin
            sh_head[c] = (n[c] != 0) ? 11'(base) : NIL_LINK;
            for (int i = 0; i < n[c]; i++)
            begin
                sh_cls[base + i] = 2'(c);
                sh_link[base + i] = (i + 1 < n[c]) ? 11'(base + i + 1) : NIL_LINK;
            end
            base += n[c];
        end
        sh_pool_n = base;
        sh_busy_n = 0;
        sh_last_sweep = '0;
        pool_ready = 1;
        live_handles.delete();
    endfunction

    // Apply one transfer to the shadow state and return the result it must give.
    function automatic slab_result_t predict_result(input mode_t m, input logic [23:0] sz,
                                                    input logic [31:0] tmo,
                                                    input logic [9:0] h,
                                                    input logic [31:0] now);
        slab_result_t r;
        logic [10:0]  idx;
        r = '{STS_OK, '0, '0, '0, '0, '0};
        case (m)
            MODE_INIT:
                build_pool(r);
            MODE_ALLOC:
            begin
                r.st = STS_NO_FREE;
                for (int c = 0; c < 3; c++)
                begin
                    if ({7'd0, class_bytes(c)} < sz)
                        continue;
                    idx = sh_head[c];
                    if (idx >= 11'(MAX_SLOTS))
                        continue;
                    sh_head[c] = sh_link[idx];
                    sh_busy[idx] = 1;
                    sh_cls[idx] = 2'(c);
                    sh_refs[idx] = '0;
                    sh_born[idx] = now;
                    sh_life[idx] = tmo;
                    sh_busy_n++;
                    live_handles.push_back(idx[9:0]);
                    if (live_handles.size() > 40)
                        void'(live_handles.pop_front());
                    r.st = STS_OK;
                    r.hnd = idx[9:0];
                    r.cls = 2'(c);
                    r.cap = class_bytes(c);
                    break;
                end
            end
            MODE_ACQUIRE:
            begin
                if (sh_refs[h] == REF_MAX)
                    r.st = STS_REF_OVF;
                else
                    sh_refs[h]++;
                r.refs = sh_refs[h];
            end
            MODE_RELEASE:
            begin
                if (sh_refs[h] != 0)
                    sh_refs[h]--;
                r.refs = sh_refs[h];
            end
            MODE_INVAL:
                if (sh_busy[h])
                begin
                    sh_refs[h] = '0;
                    sh_life[h] = '0;
                end
            MODE_GC:
                run_sweep(now, r);
            MODE_GC_FORCE:
            begin
                sh_last_sweep = '0;
                run_sweep(now, r);
            end
            default:
            begin
                if (sh_busy_n * 5 > sh_pool_n * 4)
                    sh_last_sweep = '0;
                run_sweep(now, r);
            end
        endcase
        return r;
    endfunction

    // Offer one transfer, hold it until taken, then record its prediction.
    task automatic send_op(input mode_t m, input logic [23:0] sz, input logic [31:0] tmo,
                           input logic [9:0] h, input logic [31:0] now);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        alloc_size   <= sz;
        timeout_secs <= tmo;
        slot_handle  <= h;
        now_time     <= now;
        do
            @(posedge clk);
        while (!in_ready);
        pending_q.push_back(predict_result(m, sz, tmo, h, now));
        items_sent++;
    endtask

    // Drop valid and wait until every prediction has been matched.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write all six registers while the block is idle.
    task automatic load_config(input logic [4:0] l0, l1, l2, input logic [9:0] n0, n1, n2);
        logic [9:0] v [6];
        logic [2:0] addr [6];
        drain();
        v = '{10'(l0), 10'(l1), 10'(l2), n0, n1, n2};
        addr = '{CFG_SMALL_LOG2, CFG_MEDIUM_LOG2, CFG_LARGE_LOG2,
                 CFG_SMALL_CNT, CFG_MEDIUM_CNT, CFG_LARGE_CNT};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addr[i];
            cfg_wdata <= v[i];
            @(posedge clk);
            if (i < 3)
                sh_log2[i] = v[i][4:0];
            else
                sh_count[i - 3] = v[i];
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] tick(input int unsigned step);
        clock_secs += step;
        return clock_secs;
    endfunction

    // Opening checks: empty pool, class edges, throttle, invalidate, rejected init.
    task automatic test_directed;
        send_op(MODE_ALLOC, 24'd1, '0, '0, tick(0));
        send_op(MODE_INIT, '0, '0, '0, tick(1));
        send_op(MODE_ALLOC, 24'd0, 32'd0, '0, tick(1));
        send_op(MODE_ALLOC, 24'd64, 32'd3, '0, tick(0));
        send_op(MODE_ALLOC, 24'd65, 32'hFFFF_FFFF, '0, tick(0));
        send_op(MODE_ALLOC, 24'd1024, 32'd0, '0, tick(0));
        send_op(MODE_ALLOC, 24'd1025, 32'd0, '0, tick(0));
        send_op(MODE_ALLOC, 24'hFF_FFFF, 32'd0, '0, tick(0));
        send_op(MODE_ACQUIRE, '0, '0, 10'd0, tick(0));
        send_op(MODE_RELEASE, '0, '0, 10'd0, tick(0));
        send_op(MODE_RELEASE, '0, '0, 10'd0, tick(0));        // count stays at zero
        send_op(MODE_ACQUIRE, '0, '0, 10'd1023, tick(0));     // idle slot still counts
        send_op(MODE_INVAL, '0, '0, 10'd1023, tick(0));       // idle: no effect
        send_op(MODE_ACQUIRE, '0, '0, 10'd64, tick(0));
        send_op(MODE_INVAL, '0, '0, 10'd64, tick(0));
        send_op(MODE_GC, '0, '0, '0, tick(1));                 // throttled
        send_op(MODE_GC, '0, '0, '0, tick(10));                // expiry and zero count
        send_op(MODE_GC_FORCE, '0, '0, '0, tick(1));
        send_op(MODE_GC_AUTO, '0, '0, '0, tick(1));
        // Fill the large class past 80% so auto mode forces.
        load_config(5'd0, 5'd0, 5'd16, 10'd0, 10'd0, 10'd5);
        send_op(MODE_INIT, '0, '0, '0, tick(1));
        for (int i = 0; i < 6; i++)
            send_op(MODE_ALLOC, 24'd2, 32'd0, '0, tick(0));  // last one finds none
        send_op(MODE_GC_AUTO, '0, '0, '0, tick(1));
        send_op(MODE_ALLOC, 24'd65536, '0, '0, 32'hFFFF_FFFE);
        send_op(MODE_GC_AUTO, '0, '0, '0, 32'h0000_0002);     // wrapped time
        load_config(5'd31, 5'd16, 5'd20, 10'd1023, 10'd600, 10'd1);
        send_op(MODE_INIT, '0, '0, '0, tick(1));               // counts exceed slots
        clock_secs = 32'd100;
        drain();
    endtask

    // Pile references onto one slot, then release one.
    task automatic test_ref_counts;
        load_config(5'd6, 5'd8, 5'd10, 10'd64, 10'd64, 10'd12);
        send_op(MODE_INIT, '0, '0, '0, tick(1));
        send_op(MODE_ALLOC, 24'd8, '0, '0, tick(0));
        for (int i = 0; i < 20; i++)
            send_op(MODE_ACQUIRE, '0, '0, 10'd63, tick(0));
        send_op(MODE_RELEASE, '0, '0, 10'd63, tick(0));
        drain();
    endtask

    // Random traffic, mostly on slots that were granted recently.
    task automatic random_burst(input int n);
        mode_t       m;
        int          pick;
        logic [23:0] sz;
        logic [31:0] tmo;
        logic [9:0]  h;
        int          cmax;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (!pool_ready || pick < 4)      m = MODE_INIT;
            else if (pick < 40)               m = MODE_ALLOC;
            else if (pick < 62)               m = MODE_ACQUIRE;
            else if (pick < 78)               m = MODE_RELEASE;
            else if (pick < 86)               m = MODE_INVAL;
            else if (pick < 92)               m = MODE_GC;
            else if (pick < 95)               m = MODE_GC_FORCE;
            else                              m = MODE_GC_AUTO;
            cmax = 1 << ((sh_log2[2] > 5'd16) ? 16 : sh_log2[2]);
            sz = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(cmax + 1));
            case ($urandom_range(3))
                0, 1:    tmo = '0;
                2:       tmo = $urandom_range(1, 30);
                default: tmo = $urandom;
            endcase
            if (live_handles.size() != 0 && $urandom_range(99) < 80)
                h = live_handles[$urandom_range(live_handles.size() - 1)];
            else
                h = 10'($urandom);
            if ($urandom_range(49) == 0)
                clock_secs = $urandom;
            send_op(m, sz, tmo, h, tick($urandom_range(3)));
        end
    endtask

    task automatic test_random_traffic;
        snd_idle_pct = 18;
        rcv_idle_pct = 49;
        load_config(5'd3, 5'd7, 5'd12, 10'd40, 10'd30, 10'd10);
        random_burst(100);
        snd_idle_pct = 49;
        rcv_idle_pct = 18;
        load_config(5'd1, 5'd1, 5'd16, 10'd512, 10'd1, 10'd511);
        random_burst(100);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        load_config(5'd0, 5'd9, 5'd31, 10'd3, 10'd0, 10'd1023);
        random_burst(100);
        drain();
    endtask

    // Stall the output long enough for the block to back up, then send a random burst.
    task automatic test_backpressure;
        load_config(5'd4, 5'd6, 5'd8, 10'd16, 10'd16, 10'd16);
        send_op(MODE_INIT, '0, '0, '0, tick(1));
        drain();
        hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send_op(MODE_ALLOC, 24'($urandom_range(300)), '0, '0, tick(0));
        drain();
        random_burst(20);
        drain();
    endtask

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        mode         = '0;
        alloc_size   = '0;
        timeout_secs = '0;
        slot_handle  = '0;
        now_time     = '0;
        cycles       = 0;
        mismatches   = 0;
        results_seen = 0;
        items_sent   = 0;
        hold_cycles  = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        pool_ready   = 0;
        clock_secs   = '0;
        sh_log2      = '{5'd6, 5'd8, 5'd10};
        sh_count     = '{10'd64, 10'd64, 10'd12};
        sh_head      = '{NIL_LINK, NIL_LINK, NIL_LINK};
        sh_last_sweep = '0;
        sh_busy_n    = 0;
        sh_pool_n    = 0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            sh_link[i] = NIL_LINK;
            sh_busy[i] = 0;
            sh_cls[i]  = '0;
            sh_refs[i] = '0;
            sh_born[i] = '0;
            sh_life[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_ref_counts();
        test_random_traffic();
        test_backpressure();

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("covered init, alloc fall-through, ref counting, invalidate, output stalls,");
        $display("throttled/forced/auto sweeps: %0d transfers in, %0d results, %0d bad",
                 items_sent, results_seen, mismatches);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/sac_pkg.sv
hw/rtl/sac_ram.sv
hw/rtl/slab_allocator_with_refcount_gc.sv
sim/tb.sv
